// ===== hdl/csc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the 2-D curl stencil.
// No dependencies.
`default_nettype none

package csc_pkg;

    localparam int DATA_W      = 32;
    localparam int VALUE_W     = 32;
    localparam int ROW_LEN_W   = 11;
    localparam int ROW_CNT_W   = 16;
    localparam int COL_W       = 10;
    localparam int MAX_ROW_LEN = 1024;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int PROD_W      = DATA_W + DIFF_W;
    localparam int TERM_W      = PROD_W - 16;
    localparam int SUM_W       = TERM_W + 1;
    localparam int VEC_W       = 3 * DATA_W;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = QPTR_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 2'd3;

    typedef struct packed {
        logic signed [DATA_W-1:0] z;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] x;
    } vec_t;

    typedef struct packed {
        logic [ROW_CNT_W-1:0]     row;
        logic [COL_W-1:0]         col;
        logic                     last;
        logic signed [DIFF_W-1:0] dzc;
        logic signed [DIFF_W-1:0] dzr;
        logic signed [DIFF_W-1:0] dyr;
        logic signed [DIFF_W-1:0] dxn;
    } job_t;

    typedef struct packed {
        logic              sat;
        logic [VALUE_W-1:0] val;
    } sat_t;

    function automatic logic signed [DIFF_W-1:0] diff(input logic signed [DATA_W-1:0] a,
                                                     input logic signed [DATA_W-1:0] b);
        return $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
    endfunction

    // round half up to Q16.16: add half LSB, then floor
    function automatic logic signed [TERM_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] s;
        s = p + PROD_W'(32768);
        return s[PROD_W-1:16];
    endfunction

    function automatic sat_t saturate(input logic signed [SUM_W-1:0] v);
        sat_t r;
        r.sat = ~((&v[SUM_W-1:VALUE_W-1]) | ~(|v[SUM_W-1:VALUE_W-1]));
        if (r.sat)
        begin
            r.val = {v[SUM_W-1], {(VALUE_W-1){~v[SUM_W-1]}}};
        end
        else
        begin
            r.val = v[VALUE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/csc_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies.
`default_nettype none

module csc_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== hdl/csc_front.sv =====
// Front end: position tracking, row line buffers and stencil differences.
// Depends on csc_pkg and csc_ram.
`default_nettype none

module csc_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [csc_pkg::ROW_LEN_W-1:0]  row_length,
    input  wire logic [csc_pkg::ROW_CNT_W-1:0]  row_count,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire csc_pkg::vec_t                  cur,
    input  wire logic                           start,
    input  wire logic [csc_pkg::QLVL_W-1:0]     q_level,
    output logic                                push,
    output csc_pkg::job_t                       push_job
);

    localparam int RLW = csc_pkg::ROW_LEN_W;
    localparam int RCW = csc_pkg::ROW_CNT_W;
    localparam int CW  = csc_pkg::COL_W;

    logic [RCW-1:0] row_reg;
    logic [CW-1:0]  col_reg;
    logic           s1_valid_reg;

    csc_pkg::vec_t  left_reg, prev_cur_reg, first_reg;
    csc_pkg::vec_t  s1_left_reg, s1_cur_reg, s1_first_reg;
    logic           s1_use_first_reg, s1_last_reg;
    logic [RCW-1:0] s1_row_reg;
    logic [CW-1:0]  s1_col_reg;

    logic [RLW-1:0] rl_e;
    logic [RCW-1:0] rc_e, r0, r1;
    logic [RLW-1:0] c0;
    logic [CW-1:0]  c1, rd_addr;
    logic           halted, wrap, run, accept, col_end;
    csc_pkg::vec_t  mid, above, left, right;
    logic [csc_pkg::VEC_W-1:0] newer_rd, older_rd;

    always_comb
    begin
        if (row_length < RLW'(3))
        begin
            rl_e = RLW'(3);
        end
        else if (row_length > RLW'(csc_pkg::MAX_ROW_LEN))
        begin
            rl_e = RLW'(csc_pkg::MAX_ROW_LEN);
        end
        else
        begin
            rl_e = row_length;
        end
        rc_e    = (row_count < RCW'(3)) ? RCW'(3) : row_count;
        r0      = start ? '0 : row_reg;
        c0      = start ? '0 : {1'b0, col_reg};
        halted  = r0 >= rc_e;
        wrap    = c0 >= rl_e;
        r1      = r0 + RCW'(wrap);
        c1      = wrap ? '0 : c0[CW-1:0];
        run     = !halted && (r1 < rc_e);
        col_end = ({1'b0, c1} + RLW'(1)) >= rl_e;
        rd_addr = col_end ? '0 : c1 + CW'(1);
        in_ready = ({1'b0, q_level} + (csc_pkg::QLVL_W + 1)'(s1_valid_reg))
                   < (csc_pkg::QLVL_W + 1)'(csc_pkg::QUEUE_DEPTH);
        accept  = in_valid && in_ready;
        mid     = newer_rd;
        left    = (c1 == '0) ? prev_cur_reg : left_reg;
    end

    csc_ram #(.WIDTH(csc_pkg::VEC_W), .DEPTH(csc_pkg::MAX_ROW_LEN)) u_newer (
        .clk   (clk),
        .we    (accept && run),
        .waddr (c1),
        .wdata (cur),
        .re    (accept && run),
        .raddr (rd_addr),
        .rdata (newer_rd)
    );

    csc_ram #(.WIDTH(csc_pkg::VEC_W), .DEPTH(csc_pkg::MAX_ROW_LEN)) u_older (
        .clk   (clk),
        .we    (accept && run),
        .waddr (c1),
        .wdata (mid),
        .re    (accept && run),
        .raddr (c1),
        .rdata (older_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && run && (r1 >= RCW'(2));
            if (accept && !halted)
            begin
                if (!run)
                begin
                    row_reg <= r1;
                    col_reg <= '0;
                end
                else if (col_end)
                begin
                    row_reg <= r1 + RCW'(1);
                    col_reg <= '0;
                end
                else
                begin
                    row_reg <= r1;
                    col_reg <= c1 + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && run)
        begin
            left_reg         <= mid;
            prev_cur_reg     <= cur;
            if (c1 == '0)
            begin
                first_reg <= mid;
            end
            s1_left_reg      <= left;
            s1_cur_reg       <= cur;
            s1_first_reg     <= first_reg;
            s1_use_first_reg <= col_end;
            s1_row_reg       <= r1 - RCW'(1);
            s1_col_reg       <= c1;
            s1_last_reg      <= (r1 == rc_e - RCW'(1)) && ({1'b0, c1} == rl_e - RLW'(1));
        end
    end

    always_comb
    begin
        above         = older_rd;
        right         = s1_use_first_reg ? s1_first_reg : csc_pkg::vec_t'(newer_rd);
        push          = s1_valid_reg;
        push_job.row  = s1_row_reg;
        push_job.col  = s1_col_reg;
        push_job.last = s1_last_reg;
        push_job.dzc  = csc_pkg::diff(right.z, s1_left_reg.z);
        push_job.dzr  = csc_pkg::diff(above.z, s1_cur_reg.z);
        push_job.dyr  = csc_pkg::diff(s1_cur_reg.y, above.y);
        push_job.dxn  = csc_pkg::diff(s1_left_reg.x, right.x);
    end

endmodule

`default_nettype wire

// ===== hdl/csc_queue.sv =====
// Short job queue between the front end and the arithmetic back end.
// Depends on csc_pkg.
`default_nettype none

module csc_queue (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire csc_pkg::job_t              push_job,
    input  wire logic                       pop,
    output csc_pkg::job_t                   head_job,
    output logic [csc_pkg::QLVL_W-1:0]      level
);

    localparam int PW = csc_pkg::QPTR_W;
    localparam int LW = csc_pkg::QLVL_W;

    csc_pkg::job_t slots [csc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [LW-1:0] level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            level_reg <= level_reg + LW'(push) - LW'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = slots[rd_ptr_reg];
    assign level    = level_reg;

endmodule

`default_nettype wire

// ===== hdl/csc_back.sv =====
// Back end: coefficient products, rounding, saturation and output register.
// Depends on csc_pkg.
`default_nettype none

module csc_back (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic signed [csc_pkg::DATA_W-1:0] coef_x,
    input  wire logic signed [csc_pkg::DATA_W-1:0] coef_y,
    input  wire logic [csc_pkg::QLVL_W-1:0]  q_level,
    input  wire csc_pkg::job_t               head_job,
    output logic                             pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [csc_pkg::VALUE_W-1:0]      curl_x,
    output logic [csc_pkg::VALUE_W-1:0]      curl_y,
    output logic [csc_pkg::VALUE_W-1:0]      curl_z,
    output logic [csc_pkg::ROW_CNT_W-1:0]    out_row,
    output logic [csc_pkg::COL_W-1:0]        out_col,
    output logic                             sat_flag,
    output logic                             field_last
);

    localparam int PW = csc_pkg::PROD_W;
    localparam int TW = csc_pkg::TERM_W;
    localparam int SW = csc_pkg::SUM_W;

    logic en;
    logic p_valid_reg, t_valid_reg, o_valid_reg;

    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [csc_pkg::ROW_CNT_W-1:0] p_row_reg, t_row_reg, o_row_reg;
    logic [csc_pkg::COL_W-1:0]     p_col_reg, t_col_reg, o_col_reg;
    logic                          p_last_reg, t_last_reg, o_last_reg;
    logic signed [TW-1:0]          tx_reg, ty_reg;
    logic signed [SW-1:0]          tz_reg;
    logic [csc_pkg::VALUE_W-1:0]   ox_reg, oy_reg, oz_reg;
    logic                          o_sat_reg;
    csc_pkg::sat_t                 sx, sy, sz;

    assign en  = !o_valid_reg || out_ready;
    assign pop = en && (q_level != '0);

    always_comb
    begin
        sx = csc_pkg::saturate(SW'(tx_reg));
        sy = csc_pkg::saturate(SW'(ty_reg));
        sz = csc_pkg::saturate(tz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            t_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= pop;
            t_valid_reg <= p_valid_reg;
            o_valid_reg <= t_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg     <= coef_y * head_job.dzc;
            p1_reg     <= coef_x * head_job.dzr;
            p2_reg     <= coef_x * head_job.dyr;
            p3_reg     <= coef_y * head_job.dxn;
            p_row_reg  <= head_job.row;
            p_col_reg  <= head_job.col;
            p_last_reg <= head_job.last;

            tx_reg     <= csc_pkg::round_q(p0_reg);
            ty_reg     <= csc_pkg::round_q(p1_reg);
            tz_reg     <= SW'(csc_pkg::round_q(p2_reg)) + SW'(csc_pkg::round_q(p3_reg));
            t_row_reg  <= p_row_reg;
            t_col_reg  <= p_col_reg;
            t_last_reg <= p_last_reg;

            ox_reg     <= sx.val;
            oy_reg     <= sy.val;
            oz_reg     <= sz.val;
            o_sat_reg  <= sx.sat | sy.sat | sz.sat;
            o_row_reg  <= t_row_reg;
            o_col_reg  <= t_col_reg;
            o_last_reg <= t_last_reg;
        end
    end

    assign out_valid  = o_valid_reg;
    assign curl_x     = ox_reg;
    assign curl_y     = oy_reg;
    assign curl_z     = oz_reg;
    assign out_row    = o_row_reg;
    assign out_col    = o_col_reg;
    assign sat_flag   = o_sat_reg;
    assign field_last = o_last_reg;

endmodule

`default_nettype wire

// ===== hdl/curl_2d_periodic_stencil.sv =====
// Streaming 2-D central-difference curl with periodic columns: top level.
// Depends on csc_pkg, csc_front, csc_queue, csc_back.
//
// Takes one grid point per cycle in raster order and returns the curl of
// each interior row one row later, one result per cycle sustained. A point
// is accepted every cycle while the four-entry job queue, counting the job
// being staged for it, has room. The line buffers are read at the edge
// that accepts the point that completes a result. From there the result
// passes through the queue write, the multiply stage, the round/sum stage
// and the saturating output register before it is presented. A stalled
// output freezes the back end and the queue then fills. Line buffers are
// not cleared: results of a field depend only on its own points, and the
// first two rows yield none.
`default_nettype none

module curl_2d_periodic_stencil (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [csc_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [csc_pkg::DATA_W-1:0]      cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [95:0]                     s_tdata,  // comp_x, comp_y, comp_z
    input  wire logic                            s_tuser,  // field_start
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [127:0]                         m_tdata,  // curl_x, curl_y, curl_z,
                                                           // out_row, out_col, zero pad
    output logic                                 m_tuser,  // sat_flag
    output logic                                 m_tlast   // field_last
);

    logic signed [csc_pkg::DATA_W-1:0]    coef_x_reg, coef_y_reg;
    logic [csc_pkg::ROW_LEN_W-1:0]        row_length_reg;
    logic [csc_pkg::ROW_CNT_W-1:0]        row_count_reg;

    logic                                 push, pop;
    csc_pkg::job_t                        push_job, head_job;
    logic [csc_pkg::QLVL_W-1:0]           q_level;
    logic [csc_pkg::VALUE_W-1:0]          curl_x, curl_y, curl_z;
    logic [csc_pkg::ROW_CNT_W-1:0]        out_row;
    logic [csc_pkg::COL_W-1:0]            out_col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg     <= 32'sd65536;
            coef_y_reg     <= 32'sd65536;
            row_length_reg <= csc_pkg::ROW_LEN_W'(1024);
            row_count_reg  <= csc_pkg::ROW_CNT_W'(1024);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                csc_pkg::REG_COEF_X:     coef_x_reg     <= cfg_data;
                csc_pkg::REG_COEF_Y:     coef_y_reg     <= cfg_data;
                csc_pkg::REG_ROW_LENGTH: row_length_reg <= cfg_data[csc_pkg::ROW_LEN_W-1:0];
                csc_pkg::REG_ROW_COUNT:  row_count_reg  <= cfg_data[csc_pkg::ROW_CNT_W-1:0];
                default:                 coef_x_reg     <= coef_x_reg;
            endcase
        end
    end

    csc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .row_length (row_length_reg),
        .row_count  (row_count_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .cur        (csc_pkg::vec_t'(s_tdata)),
        .start      (s_tuser),
        .q_level    (q_level),
        .push       (push),
        .push_job   (push_job)
    );

    csc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .level    (q_level)
    );

    csc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .coef_x     (coef_x_reg),
        .coef_y     (coef_y_reg),
        .q_level    (q_level),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .curl_x     (curl_x),
        .curl_y     (curl_y),
        .curl_z     (curl_z),
        .out_row    (out_row),
        .out_col    (out_col),
        .sat_flag   (m_tuser),
        .field_last (m_tlast)
    );

    assign m_tdata = {6'b0, out_col, out_row, curl_z, curl_y, curl_x};

endmodule

`default_nettype wire

// ===== tb/tb_curl_2d_periodic_stencil.sv =====
// Testbench for curl_2d_periodic_stencil: directed and random vector fields,
// checked item by item against a built-in line-buffer curl predictor.
// Depends on csc_pkg and the curl_2d_periodic_stencil RTL.
`timescale 1ns / 100ps

module tb_curl_2d_periodic_stencil;

    localparam int LIMIT_CYCLES = 600000;

    typedef struct {
        longint x;
        longint y;
        longint z;
    } point_t;

    typedef struct {
        bit [31:0] cx;
        bit [31:0] cy;
        bit [31:0] cz;
        bit [15:0] row;
        bit [9:0]  col;
        bit        sat;
        bit        last;
    } curl_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_idx = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic         m_tuser;
    logic         m_tlast;

    curl_2d_periodic_stencil u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // predictor state
    longint  coef_x = 65536;
    longint  coef_y = 65536;
    int      row_len_reg = 1024;
    int      row_cnt_reg = 1024;
    point_t  older_line [csc_pkg::MAX_ROW_LEN];
    point_t  newer_line [csc_pkg::MAX_ROW_LEN];
    point_t  left_pt;
    point_t  first_pt;
    int      cur_row = 0;
    int      cur_col = 0;

    curl_t   curl_q [$];
    int      n_err = 0;
    int      n_points = 0;
    int      cycles = 0;
    bit      no_idle = 1'b0;

    function automatic longint sext32(bit [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint rnd_term(longint c, longint d);
        longint p;
        p = c * d + 32768;
        return p >>> 16;
    endfunction

    function automatic longint clip32(longint v, inout bit f);
        if (v > 64'sd2147483647)
        begin
            f = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            f = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic int eff_len();
        if (row_len_reg < 3)
            return 3;
        if (row_len_reg > csc_pkg::MAX_ROW_LEN)
            return csc_pkg::MAX_ROW_LEN;
        return row_len_reg;
    endfunction

    function automatic int eff_rows();
        return (row_cnt_reg < 3) ? 3 : row_cnt_reg;
    endfunction

    task automatic predict_curl(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit start);
        int     rl;
        int     rc;
        int     c;
        point_t cur;
        point_t mid;
        point_t above;
        point_t lft;
        point_t rgt;
        curl_t  e;
        bit     f;
        rl = eff_len();
        rc = eff_rows();
        if (start)
        begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_row >= rc)
            return;
        if (cur_col >= rl)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= rc)
                return;
        end
        c = cur_col;
        cur.x = sext32(x);
        cur.y = sext32(y);
        cur.z = sext32(z);
        mid = newer_line[c];
        above = older_line[c];
        lft = (c > 0) ? left_pt : newer_line[rl-1];
        rgt = (c + 1 < rl) ? newer_line[c+1] : first_pt;
        if (cur_row >= 2)
        begin
            f = 1'b0;
            e.cx = 32'(clip32(rnd_term(coef_y, rgt.z - lft.z), f));
            e.cy = 32'(clip32(rnd_term(-coef_x, cur.z - above.z), f));
            e.cz = 32'(clip32(rnd_term(coef_x, cur.y - above.y)
                              + rnd_term(-coef_y, rgt.x - lft.x), f));
            e.row = 16'(cur_row - 1);
            e.col = 10'(c);
            e.sat = f;
            e.last = (cur_row == rc - 1) && (c == rl - 1);
            curl_q.push_back(e);
        end
        if (c == 0)
            first_pt = mid;
        left_pt = mid;
        older_line[c] = mid;
        newer_line[c] = cur;
        if (c + 1 >= rl)
        begin
            cur_col = 0;
            cur_row++;
        end
        else
        begin
            cur_col = c + 1;
        end
    endtask

    // must be called at a rising edge; returns at the edge that accepts the item
    task automatic send_point(bit [31:0] x, bit [31:0] y, bit [31:0] z, bit start);
        bit acc;
        if (!no_idle && $urandom_range(0, 99) < 30)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        s_tuser <= start;
        do
        begin
            @(negedge clk);
            acc = s_tready;
            @(posedge clk);
        end
        while (!acc);
        predict_curl(x, y, z, start);
        n_points++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (curl_q.size() == 0);
        @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [31:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            csc_pkg::REG_COEF_X:     coef_x = sext32(val);
            csc_pkg::REG_COEF_Y:     coef_y = sext32(val);
            csc_pkg::REG_ROW_LENGTH: row_len_reg = int'(val[10:0]);
            default:                 row_cnt_reg = int'(val[15:0]);
        endcase
        @(posedge clk);
    endtask

    function automatic bit [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
            2: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
            default: return 32'(int'($urandom_range(0, 33554432)) - 16777216);
        endcase
    endfunction

    // whole field; cut_at < 0 sends every point, extra adds ignored points
    task automatic send_field(int cut_at, int extra);
        int total;
        total = eff_len() * eff_rows();
        if (cut_at >= 0 && cut_at < total)
            total = cut_at;
        for (int i = 0; i < total; i++)
            send_point(rand_val(), rand_val(), rand_val(), i == 0);
        for (int i = 0; i < extra; i++)
            send_point($urandom, $urandom, $urandom, 1'b0);
    endtask

    task automatic test_extremes();
        bit [31:0] hi;
        bit [31:0] lo;
        hi = 32'h7fffffff;
        lo = 32'h80000000;
        write_reg(csc_pkg::REG_COEF_X, 32'h80000000);
        write_reg(csc_pkg::REG_COEF_Y, 32'h7fffffff);
        write_reg(csc_pkg::REG_ROW_LENGTH, 32'd3);
        write_reg(csc_pkg::REG_ROW_COUNT, 32'd3);
        for (int i = 0; i < 9; i++)
            send_point((i % 2) ? hi : lo, (i % 3) ? lo : hi, (i < 4) ? hi : lo, i == 0);
        send_point(hi, lo, hi, 1'b0);
        settle();
        write_reg(csc_pkg::REG_COEF_X, 32'h00008000);
        write_reg(csc_pkg::REG_COEF_Y, 32'hffff0000);
        write_reg(csc_pkg::REG_ROW_LENGTH, 32'hfffff801);
        write_reg(csc_pkg::REG_ROW_COUNT, 32'hffff0000);
        for (int i = 0; i < 9; i++)
            send_point(32'(i * 65536), 32'(-i * 3000), 32'(i * i * 777), i == 0);
        settle();
    endtask

    task automatic test_wide_row();
        write_reg(csc_pkg::REG_COEF_X, 32'h00010000);
        write_reg(csc_pkg::REG_COEF_Y, 32'h00004000);
        write_reg(csc_pkg::REG_ROW_LENGTH, 32'd150);
        write_reg(csc_pkg::REG_ROW_COUNT, 32'd3);
        send_field(-1, 0);
        settle();
    endtask

    task automatic test_random_fields();
        int phase;
        phase = 0;
        while (n_points < 1400)
        begin
            no_idle = (phase >= 8 && phase < 12);
            write_reg(csc_pkg::REG_COEF_X, ($urandom_range(0, 3) == 0) ? $urandom : rand_val());
            write_reg(csc_pkg::REG_COEF_Y, ($urandom_range(0, 3) == 0) ? $urandom : rand_val());
            write_reg(csc_pkg::REG_ROW_LENGTH,
                      {21'($urandom), 11'($urandom_range(0, 12))});
            write_reg(csc_pkg::REG_ROW_COUNT,
                      {16'($urandom), 16'($urandom_range(0, 8))});
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 5))
                    0: send_field($urandom_range(1, 30), 0);
                    1: send_field(-1, $urandom_range(1, 4));
                    default: send_field(-1, 0);
                endcase
            end
            settle();
            phase++;
        end
        no_idle = 1'b0;
    endtask

    always @(posedge clk)
    begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= 30);
    end

    always @(negedge clk)
    begin
        curl_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (curl_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("unexpected result row %0d col %0d",
                             m_tdata[111:96], m_tdata[121:112]);
            end
            else
            begin
                e = curl_q.pop_front();
                if (m_tdata[31:0] !== e.cx || m_tdata[63:32] !== e.cy
                    || m_tdata[95:64] !== e.cz || m_tdata[111:96] !== e.row
                    || m_tdata[121:112] !== e.col || m_tdata[127:122] !== 6'd0
                    || m_tuser !== e.sat || m_tlast !== e.last)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch exp %h %h %h r%0d c%0d s%0b l%0b got %h s%0b l%0b",
                                 e.cx, e.cy, e.cz, e.row, e.col, e.sat, e.last,
                                 m_tdata, m_tuser, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_wide_row();
        test_random_fields();
        settle();
        if (n_err == 0 && curl_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
